>>> sv/array_axis_sum_reduce_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the array axis sum reduce core
// Clocked assertion forms, with and without the reset qualifier.
// ----------------------------------------------------------------------------
`ifndef ARRAY_AXIS_SUM_REDUCE_CORE_MACROS_SVH
`define ARRAY_AXIS_SUM_REDUCE_CORE_MACROS_SVH

// assertion that is off while reset is asserted
`define AASR_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// assertion that also checks across reset
`define AASR_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> sv/aasr_pkg.sv
// ----------------------------------------------------------------------------
// aasr_pkg
// Shared constants, types and helpers of the array axis sum reduce core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package aasr_pkg;

    localparam int MAX_DIMS   = 4;
    localparam int OUT_DEPTH  = 4096;
    localparam int DIM_BITS   = 12;

    localparam int AX_W       = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int D_W        = $clog2(MAX_DIMS + 1);
    localparam int EXT_W      = DIM_BITS + 1;
    localparam int IDX_W      = $clog2(OUT_DEPTH);
    localparam int SIZE_W     = $clog2(OUT_DEPTH + 1);

    localparam int NUM_DIMS_W = 3;
    localparam int DSIZE_W    = 13;
    localparam int KEEP_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int RIDX_W     = 12;

    localparam int S_TDATA_W  = 80;
    localparam int M_TDATA_W  = 64;

    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = 1;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_DIMS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_SIZE_0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_SIZE_1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_SIZE_2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_SIZE_3 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_KEEP_MASK  = 3'd5;

    localparam logic ACT_ELEMENT = 1'b0;
    localparam logic ACT_READ    = 1'b1;

    localparam logic [63:0] CANON_NAN = 64'h7FF8_0000_0000_0000;

    typedef struct packed {
        logic             is_read;
        logic             flag;     // element: first contribution; read: index in range
        logic [IDX_W-1:0] idx;
        logic [63:0]      bits;
    } t_cmd;

    function automatic logic [EXT_W-1:0] f_clamp_ext(input logic [DSIZE_W-1:0] v);
        logic [EXT_W-1:0] top;
        top = EXT_W'(1) << DIM_BITS;
        if (v == '0) begin
            return EXT_W'(1);
        end else if ({{(EXT_W+DSIZE_W){1'b0}}, v} > {{DSIZE_W{1'b0}}, {EXT_W{1'b0}}, top}) begin
            return top;
        end
        return EXT_W'(v);
    endfunction

    function automatic logic [D_W-1:0] f_clamp_dims(input logic [NUM_DIMS_W-1:0] v);
        if (v == '0) begin
            return D_W'(1);
        end else if ({{D_W{1'b0}}, v} > (NUM_DIMS_W + D_W)'(MAX_DIMS)) begin
            return D_W'(MAX_DIMS);
        end
        return D_W'(v);
    endfunction

endpackage

>>> sv/array_axis_sum_reduce_core.sv
// ----------------------------------------------------------------------------
// array_axis_sum_reduce_core
// Sums a multi-dimensional array of doubles over every axis not kept.
// ----------------------------------------------------------------------------
// Usage: program num_dims, the axis extents and keep_mask on the cfg port,
// then stream elements in column-major order on the slave side (tuser low,
// tdata[63:0] the element). A beat with tuser high reads the stored sum at
// tdata[75:64]; one result beat follows on the master side with the sum in
// tdata and the in-range flag in tuser.
// Any register write restarts the array and recomputes the output size axis
// by axis, with tready low; reset does the same. Stored sums persist.
// Elements pass one at a time through the accumulator states decode, shift,
// add, normalize loop, round and write (decode goes straight to write or
// idle when the element or the stored sum is not finite, add goes to write
// when the sum cancels to zero); a read needs only decode. A 2-beat queue lets
// the input side run ahead. A read result passes the queue, the command
// register and the output register before tvalid rises. A stalled result
// waits in the output register while the input side keeps filling the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module array_axis_sum_reduce_core import aasr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [S_TDATA_W-1:0]  i_s_axis_tdata,   // element_bits, read_index, zero pad
    input  logic                  i_s_axis_tuser,   // action
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [M_TDATA_W-1:0]  o_m_axis_tdata,   // sum_bits
    output logic                  o_m_axis_tuser    // index_ok
);

    t_cmd push_cmd;
    t_cmd head_cmd;
    logic push;
    logic pop;
    logic empty;
    logic full;

    aasr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_action   (i_s_axis_tuser),
        .i_element  (i_s_axis_tdata[63:0]),
        .i_read_idx (i_s_axis_tdata[64+RIDX_W-1:64]),
        .i_full     (full),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    aasr_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (head_cmd),
        .o_empty (empty),
        .o_full  (full)
    );

    aasr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head_cmd),
        .o_pop   (pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_sum   (o_m_axis_tdata),
        .o_ok    (o_m_axis_tuser)
    );

endmodule

>>> sv/aasr_ram.sv
// ----------------------------------------------------------------------------
// aasr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aasr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/aasr_fifo.sv
// ----------------------------------------------------------------------------
// aasr_fifo
// Short command queue between the classifier and the accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aasr_fifo import aasr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_head,
    output logic o_empty,
    output logic o_full
);

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wptr;
    logic [Q_PTR_W-1:0] r_rptr;
    logic [Q_PTR_W:0]   r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (Q_PTR_W+1)'(Q_DEPTH));
    assign o_head  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> sv/aasr_front.sv
// ----------------------------------------------------------------------------
// aasr_front
// Configuration, coordinate counters and output index for each input beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aasr_front import aasr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_action,
    input  logic [63:0]           i_element,
    input  logic [RIDX_W-1:0]     i_read_idx,
    input  logic                  i_full,
    output logic                  o_push,
    output t_cmd                  o_cmd
);

    logic [NUM_DIMS_W-1:0] r_num_dims;
    logic [DSIZE_W-1:0]    r_dim_size [MAX_DIMS];
    logic [KEEP_W-1:0]     r_keep;
    logic [DIM_BITS-1:0]   r_cnt      [MAX_DIMS];
    logic [SIZE_W-1:0]     r_part     [MAX_DIMS];
    logic [SIZE_W-1:0]     r_stride   [MAX_DIMS];
    logic [SIZE_W-1:0]     r_size;
    logic                  r_ovf;
    logic                  r_busy;
    logic [AX_W-1:0]       r_ax;

    logic [D_W-1:0]          dims;
    logic [MAX_DIMS-1:0]     used;
    logic [MAX_DIMS-1:0]     kept;
    logic [MAX_DIMS-1:0]     wrap;
    logic [MAX_DIMS-1:0]     inc;
    logic [EXT_W-1:0]        ext [MAX_DIMS];
    logic [SIZE_W-1:0]       idx_sum;
    logic                    first;
    logic [SIZE_W+EXT_W-1:0] prod;
    logic                    accept;
    logic                    is_elem;

    always_comb begin
        dims    = f_clamp_dims(r_num_dims);
        idx_sum = '0;
        first   = 1'b1;
        for (int n = 0; n < MAX_DIMS; n++) begin
            used[n] = ((D_W+1)'(n) < {1'b0, dims});
            ext[n]  = (n < 4) ? f_clamp_ext(r_dim_size[n]) : EXT_W'(1);
            kept[n] = used[n] && (n < KEEP_W) && r_keep[n % KEEP_W];
            wrap[n] = ({1'b0, r_cnt[n]} + 1'b1) >= ext[n];
            idx_sum = idx_sum + r_part[n];
            if (used[n] && !kept[n] && (r_cnt[n] != '0)) begin
                first = 1'b0;
            end
        end
        inc[0] = used[0];
        for (int n = 1; n < MAX_DIMS; n++) begin
            inc[n] = inc[n-1] && wrap[n-1] && used[n];
        end
        prod = r_size * ext[r_ax];
    end

    assign o_ready = !r_busy && !i_full;
    assign accept  = i_valid && o_ready;
    assign is_elem = (i_action == ACT_ELEMENT);
    assign o_push  = accept && !(is_elem && r_ovf);

    always_comb begin
        o_cmd.is_read = !is_elem;
        o_cmd.bits    = i_element;
        if (is_elem) begin
            o_cmd.idx  = idx_sum[IDX_W-1:0];
            o_cmd.flag = first;
        end else begin
            o_cmd.idx  = i_read_idx[IDX_W-1:0];
            o_cmd.flag = !r_ovf && ({{(SIZE_W-RIDX_W){1'b0}}, i_read_idx} < r_size);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_dims <= NUM_DIMS_W'(1);
            r_keep     <= KEEP_W'(1);
            for (int n = 0; n < MAX_DIMS; n++) begin
                r_dim_size[n] <= DSIZE_W'(1);
                r_cnt[n]      <= '0;
                r_part[n]     <= '0;
                r_stride[n]   <= '0;
            end
            r_size <= SIZE_W'(1);
            r_ovf  <= 1'b0;
            r_busy <= 1'b1;
            r_ax   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_NUM_DIMS:   r_num_dims    <= i_cfg_data[NUM_DIMS_W-1:0];
                REG_DIM_SIZE_0: r_dim_size[0] <= i_cfg_data;
                REG_DIM_SIZE_1: r_dim_size[1 % MAX_DIMS] <= i_cfg_data;
                REG_DIM_SIZE_2: r_dim_size[2 % MAX_DIMS] <= i_cfg_data;
                REG_DIM_SIZE_3: r_dim_size[3 % MAX_DIMS] <= i_cfg_data;
                REG_KEEP_MASK:  r_keep        <= i_cfg_data[KEEP_W-1:0];
                default: ;
            endcase
            if (i_cfg_idx <= REG_KEEP_MASK) begin
                for (int n = 0; n < MAX_DIMS; n++) begin
                    r_cnt[n]  <= '0;
                    r_part[n] <= '0;
                end
                r_size <= SIZE_W'(1);
                r_ovf  <= 1'b0;
                r_busy <= 1'b1;
                r_ax   <= '0;
            end
        end else if (r_busy) begin
            r_stride[r_ax] <= kept[r_ax] ? r_size : '0;
            if (kept[r_ax]) begin
                if (prod > (SIZE_W+EXT_W)'(OUT_DEPTH)) begin
                    r_ovf <= 1'b1;
                end
                r_size <= prod[SIZE_W-1:0];
            end
            if (r_ax == AX_W'(MAX_DIMS - 1)) begin
                r_busy <= 1'b0;
            end else begin
                r_ax <= r_ax + 1'b1;
            end
        end else if (accept && is_elem) begin
            for (int n = 0; n < MAX_DIMS; n++) begin
                if (inc[n]) begin
                    if (wrap[n]) begin
                        r_cnt[n]  <= '0;
                        r_part[n] <= '0;
                    end else begin
                        r_cnt[n]  <= r_cnt[n] + 1'b1;
                        r_part[n] <= r_part[n] + r_stride[n];
                    end
                end
            end
        end
    end

endmodule

>>> sv/aasr_back.sv
// ----------------------------------------------------------------------------
// aasr_back
// Sum store and double-precision accumulate, read-out of stored sums.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aasr_back import aasr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_cmd        i_head,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_sum,
    output logic        o_ok
);

    typedef enum logic [2:0] {
        B_IDLE, B_DEC, B_SHIFT, B_ADD, B_NORM, B_ROUND, B_WRITE
    } t_bstate;

    t_bstate     r_state;
    t_cmd        r_cmd;
    logic        r_sx;
    logic        r_sy;
    logic [10:0] r_ex;
    logic [10:0] r_d;
    logic [52:0] r_mx;
    logic [52:0] r_my;
    logic [55:0] r_ysh;
    logic [56:0] r_sum;
    logic [11:0] r_er;
    logic [63:0] r_res;
    logic        r_out_valid;
    logic [63:0] r_out_sum;
    logic        r_out_ok;

    logic [IDX_W-1:0] raddr;
    logic [63:0]      rdata;
    logic             out_free;

    logic [63:0] a_val;
    logic [63:0] x_val;
    logic [63:0] y_val;
    logic [55:0] my_ext;
    logic [55:0] lost_mask;
    logic [55:0] ysh;
    logic        same;
    logic [56:0] add_res;
    logic [53:0] m_rnd;
    logic [52:0] m_fin;
    logic [11:0] e_fin;
    logic        rnd_up;

    assign o_pop    = (r_state == B_IDLE) && !i_empty;
    assign raddr    = o_pop ? i_head.idx : r_cmd.idx;
    assign out_free = !r_out_valid || i_ready;

    aasr_ram #(.WIDTH(64), .DEPTH(OUT_DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (r_state == B_WRITE),
        .i_waddr (r_cmd.idx),
        .i_wdata (r_res),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        a_val = r_cmd.flag ? 64'h0 : rdata;
        if (a_val[62:0] >= r_cmd.bits[62:0]) begin
            x_val = a_val;
            y_val = r_cmd.bits;
        end else begin
            x_val = r_cmd.bits;
            y_val = a_val;
        end

        my_ext    = {r_my, 3'b000};
        lost_mask = ~({56{1'b1}} << r_d);
        if (r_d >= 11'd56) begin
            ysh = {55'b0, |my_ext};
        end else begin
            ysh    = my_ext >> r_d;
            ysh[0] = ysh[0] | (|(my_ext & lost_mask));
        end

        same = (r_sx == r_sy);
        if (same) begin
            add_res = {1'b0, r_mx, 3'b000} + {1'b0, r_ysh};
        end else begin
            add_res = {1'b0, r_mx, 3'b000} - {1'b0, r_ysh};
        end

        rnd_up = r_sum[2] && (r_sum[1] || r_sum[0] || r_sum[3]);
        m_rnd  = {1'b0, r_sum[55:3]} + {53'b0, rnd_up};
        if (m_rnd[53]) begin
            m_fin = m_rnd[53:1];
            e_fin = r_er + 1'b1;
        end else begin
            m_fin = m_rnd[52:0];
            e_fin = r_er;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (o_pop) begin
                        r_cmd   <= i_head;
                        r_state <= B_DEC;
                    end
                end
                B_DEC: begin
                    if (r_cmd.is_read) begin
                        if (out_free) begin
                            r_out_valid <= 1'b1;
                            r_out_sum   <= r_cmd.flag ? rdata : 64'h0;
                            r_out_ok    <= r_cmd.flag;
                            r_state     <= B_IDLE;
                        end
                    end else if (r_cmd.bits[62:52] == 11'h7FF) begin
                        r_res   <= CANON_NAN;
                        r_state <= B_WRITE;
                    end else if (!r_cmd.flag && (rdata == CANON_NAN)) begin
                        r_state <= B_IDLE;
                    end else if (a_val[62:52] == 11'h7FF) begin
                        r_res   <= a_val;
                        r_state <= B_WRITE;
                    end else begin
                        r_sx    <= x_val[63];
                        r_sy    <= y_val[63];
                        r_ex    <= (x_val[62:52] == 11'h0) ? 11'd1 : x_val[62:52];
                        r_mx    <= {(x_val[62:52] != 11'h0), x_val[51:0]};
                        r_my    <= {(y_val[62:52] != 11'h0), y_val[51:0]};
                        r_d     <= ((x_val[62:52] == 11'h0) ? 11'd1 : x_val[62:52])
                                 - ((y_val[62:52] == 11'h0) ? 11'd1 : y_val[62:52]);
                        r_state <= B_SHIFT;
                    end
                end
                B_SHIFT: begin
                    r_ysh   <= ysh;
                    r_state <= B_ADD;
                end
                B_ADD: begin
                    if (add_res == '0) begin
                        r_res   <= {same ? r_sx : 1'b0, 63'b0};
                        r_state <= B_WRITE;
                    end else begin
                        r_sum   <= add_res;
                        r_er    <= {1'b0, r_ex};
                        r_state <= B_NORM;
                    end
                end
                B_NORM: begin
                    if (r_sum[56]) begin
                        r_sum <= {1'b0, r_sum[56:2], r_sum[1] | r_sum[0]};
                        r_er  <= r_er + 1'b1;
                    end else if (!r_sum[55] && (r_er > 12'd1)) begin
                        if ((r_sum[55:48] == 8'h0) && (r_er > 12'd8)) begin
                            r_sum <= r_sum << 8;
                            r_er  <= r_er - 12'd8;
                        end else begin
                            r_sum <= r_sum << 1;
                            r_er  <= r_er - 1'b1;
                        end
                    end else begin
                        r_state <= B_ROUND;
                    end
                end
                B_ROUND: begin
                    if (e_fin >= 12'd2047) begin
                        r_res <= {r_sx, 11'h7FF, 52'b0};
                    end else begin
                        r_res <= {r_sx, m_fin[52] ? e_fin[10:0] : 11'h0, m_fin[51:0]};
                    end
                    r_state <= B_WRITE;
                end
                B_WRITE: begin
                    r_state <= B_IDLE;
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_out_valid;
    assign o_sum   = r_out_sum;
    assign o_ok    = r_out_ok;

endmodule

>>> sv/aasr_checker.sv
// ----------------------------------------------------------------------------
// aasr_checker
// Port-level checks of the array axis sum reduce core, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "array_axis_sum_reduce_core_macros.svh"

module aasr_checker import aasr_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_cfg_we,
    input logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input logic [CFG_DATA_W-1:0] i_cfg_data,
    input logic                  i_s_axis_tvalid,
    input logic                  o_s_axis_tready,
    input logic [S_TDATA_W-1:0]  i_s_axis_tdata,
    input logic                  i_s_axis_tuser,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [M_TDATA_W-1:0]  o_m_axis_tdata,
    input logic                  o_m_axis_tuser
);

    `AASR_ASSERT_CLK(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata), "result beat changed while stalled")
    `AASR_ASSERT_CLK(a_bad_index_zero, o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tdata == '0, "out of range read returned nonzero data")
    `AASR_ASSERT_CLK(a_cfg_recalc, i_cfg_we && (i_cfg_idx <= REG_KEEP_MASK) |=> !o_s_axis_tready, "input taken during size recompute")
    `AASR_ASSERT_RST(a_reset_quiet, !i_rst_n |=> !o_m_axis_tvalid && !o_s_axis_tready, "channels active right after reset")

endmodule

bind array_axis_sum_reduce_core aasr_checker u_aasr_checker (.*);
